// ===== sv/sfd_pkg.sv =====
// Package for the stuffed frame decoder.
// Holds the phase type, the special byte codes and the result beat struct.
// No dependencies.
package sfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned USER_W = 4;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'd2;
    localparam logic [BYTE_W-1:0] ESC_ZERO   = 8'd3;
    localparam logic [BYTE_W-1:0] ESC_ONE    = 8'd4;
    localparam logic [BYTE_W-1:0] ESC_TWO    = 8'd5;

    localparam logic [KIND_W-1:0] KIND_CODE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHK  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CODE = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAY  = 3'd3,
        PH_CHK  = 3'd4
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] raw_byte;
    } sfd_in_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] kind;
        logic              frame_end;
        logic              sum_ok;
        logic              framing_error;
    } sfd_result_t;

endpackage

// ===== sv/sfd_in_stage.sv =====
// Input register of the stuffed frame decoder.
// Captures one raw byte per beat; uses sfd_pkg.
module sfd_in_stage
    import sfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              advance,
    output sfd_in_t           in_beat
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_beat.valid    = valid_reg;
    assign in_beat.raw_byte = byte_reg;

endmodule

// ===== sv/sfd_decode.sv =====
// Frame state machine of the stuffed frame decoder: unescape, phase tracking, checksum.
// Consumes the input register and produces at most one result beat per byte; uses sfd_pkg.
module sfd_decode
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sfd_in_t     in_beat,
    input  logic        advance,
    output sfd_result_t result
);

    phase_t            phase_reg, phase_next;
    logic              esc_reg, esc_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              step;
    logic              have_val;
    logic [BYTE_W-1:0] val;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] raw;

    assign step     = in_beat.valid && advance;
    assign raw      = in_beat.raw_byte;
    assign left_dec = left_reg - 8'd1;
    assign sum_add  = sum_reg + val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            esc_reg   <= 1'b0;
            left_reg  <= '0;
            sum_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        have_val   = 1'b0;
        val        = raw;
        result     = '0;

        unique case (phase_reg)
            PH_CODE, PH_LEN, PH_PAY, PH_CHK: begin
                if (raw == START_BYTE) begin
                    result.valid         = 1'b1;
                    result.framing_error = 1'b1;
                    phase_next           = PH_CODE;
                    esc_next             = 1'b0;
                    left_next            = '0;
                    sum_next             = '0;
                end else if (esc_reg) begin
                    esc_next = 1'b0;
                    priority if (raw == ESC_ZERO) begin
                        val      = 8'd0;
                        have_val = 1'b1;
                    end else if (raw == ESC_ONE) begin
                        val      = 8'd1;
                        have_val = 1'b1;
                    end else if (raw == ESC_TWO) begin
                        val      = 8'd2;
                        have_val = 1'b1;
                    end else begin
                        result.valid         = 1'b1;
                        result.framing_error = 1'b1;
                        phase_next           = PH_IDLE;
                        left_next            = '0;
                        sum_next             = '0;
                    end
                end else if (raw == ESC_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    have_val = 1'b1;
                end

                if (have_val) begin
                    result.valid    = 1'b1;
                    result.out_byte = val;
                    unique case (phase_reg)
                        PH_CODE: begin
                            result.kind = KIND_CODE;
                            sum_next    = sum_add;
                            phase_next  = PH_LEN;
                        end
                        PH_LEN: begin
                            result.kind = KIND_LEN;
                            sum_next    = sum_add;
                            left_next   = val;
                            phase_next  = (val == 8'd0) ? PH_CHK : PH_PAY;
                        end
                        PH_PAY: begin
                            result.kind = KIND_PAY;
                            sum_next    = sum_add;
                            left_next   = left_dec;
                            if (left_dec == 8'd0) begin
                                phase_next = PH_CHK;
                            end
                        end
                        default: begin
                            result.kind      = KIND_CHK;
                            result.frame_end = 1'b1;
                            result.sum_ok    = (sum_add == 8'd0);
                            phase_next       = PH_IDLE;
                            left_next        = '0;
                            sum_next         = '0;
                        end
                    endcase
                end
            end
            default: begin
                if (raw == START_BYTE) begin
                    phase_next = PH_CODE;
                    esc_next   = 1'b0;
                    left_next  = '0;
                    sum_next   = '0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase

        if (!in_beat.valid) begin
            result.valid = 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_end_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.valid && result.frame_end |=> phase_reg == PH_IDLE)
        else $error("phase not idle after checksum beat");

    a_esc_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> phase_reg != PH_IDLE)
        else $error("escape pending outside a frame");

    a_pay_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAY |-> left_reg != 8'd0)
        else $error("payload phase with no bytes left");

    a_err_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.framing_error |=> phase_reg == PH_IDLE || phase_reg == PH_CODE)
        else $error("error beat did not resynchronize");
`endif

endmodule

// ===== sv/sfd_out_stage.sv =====
// Result register of the stuffed frame decoder.
// Holds one result beat until the receiver takes it; uses sfd_pkg.
module sfd_out_stage
    import sfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  sfd_result_t       result,
    output logic              advance,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [USER_W-1:0] m_tuser
);

    logic        valid_reg;
    sfd_result_t res_reg;

    assign advance = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tlast  = res_reg.frame_end;
    assign m_tuser  = {res_reg.framing_error, res_reg.sum_ok, res_reg.kind};

endmodule

// ===== sv/stuffed_frame_decoder_top.sv =====
// Top level of the stuffed frame decoder.
// Instantiates sfd_in_stage, sfd_decode and sfd_out_stage; uses sfd_pkg.
//
// Slave channel: one raw line byte per beat on s_tdata. A zero byte opens a
// frame of code, length, payload and checksum bytes; 2 escapes the next byte
// (3, 4, 5 stand for 0, 1, 2). Bytes outside a frame produce no beat.
// Master channel: one decoded byte per beat on m_tdata, its kind and flags on
// m_tuser, m_tlast high on the checksum beat. On a framing error m_tdata,
// kind, m_tlast and sum_ok are zero. Escape and idle bytes produce no beat.
// A taken byte is decoded from the input register into the result register,
// which drives m_tvalid. Throughput: one byte per cycle while m_tready stays
// high; a single state update lies between the two registers.
// Reset (aresetn low, synchronous): both registers empty, decoder idle.
// Stall: while m_tready is low a held result blocks the decoder; if the
// input register is empty, one more byte is taken into it, then s_tready
// drops until the receiver takes the held beat.
module stuffed_frame_decoder_top
    import sfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] raw_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast,
    output logic [USER_W-1:0] m_tuser    // [1:0] kind, [2] sum_ok, [3] framing_error
);

    sfd_in_t     in_beat;
    sfd_result_t result;
    logic        advance;

    sfd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_beat  (in_beat)
    );

    sfd_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_beat (in_beat),
        .advance (advance),
        .result  (result)
    );

    sfd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
